>>> hw/rtl/gacma_pkg.sv
// Shared widths and constants for the gap-aware centered moving average.
// No dependencies; imported by the divider and the top level.
package gacma_pkg;

  localparam int VALUE_W    = 16;   // sample and result width
  localparam int CFG_W      = 6;    // window width register
  localparam int HALF_W     = 5;    // half window, 0..31
  localparam int LINE_DEPTH = 64;   // delay line entries
  localparam int PTR_W      = 6;    // delay line address
  localparam int SUM_W      = 23;   // running window sum, signed
  localparam int CNT_W      = 7;    // valid samples in window
  localparam int SEEN_W     = 7;    // samples seen, saturating
  localparam int DVD_W      = 23;   // divider dividend / quotient
  localparam int DVS_W      = 7;    // divider divisor
  localparam int QSTEP_W    = 5;    // divider step counter

  localparam logic [HALF_W-1:0] MAX_HALF_WINDOW = 5'd31;
  localparam logic [SEEN_W-1:0] SEEN_CAP        = 7'd64;
  localparam logic [CFG_W-1:0]  CFG_RESET       = 6'd51;

endpackage

>>> hw/rtl/gacma_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gacma_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/gacma_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on gacma_pkg for operand widths.
module gacma_div
  import gacma_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [QSTEP_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0]   dvd_r, dvd_nxt;
  logic [DVS_W-1:0]   dvs_r, dvs_nxt;
  logic [DVS_W-1:0]   rem_r, rem_nxt;
  logic [DVS_W:0]     rem_sh;
  logic               qbit;

  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign qbit   = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = QSTEP_W'(DVD_W - 1);
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // shift quotient bits in where dividend bits leave
      dvd_nxt = {dvd_r[DVD_W-2:0], qbit};
      rem_nxt = qbit ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
      cnt_nxt = cnt_r - QSTEP_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

>>> hw/rtl/gap_aware_centered_moving_average_top.sv
// Gap-aware centered moving average: one delay-line RAM, a serial divider
// and a step sequencer. Depends on gacma_pkg, gacma_ram and gacma_div.
//
// Usage:
//   in_*  : valid/ready channel of samples with a valid bit and an end mark.
//   out_* : valid/ready channel of smoothed results, one per source sample.
//   cfg_* : window width, written while the block is idle; a new width takes
//           effect with the first sample of the next stream.
// With half window h, output i leaves with input i+h. The input marked as
// stream end also flushes the remaining outputs and clears the window.
// Flow: one sample at a time, in_ready is low from accept until the
// sequencer is back in idle. Bookkeeping plus the window drop read come
// first. A valid output adds the RAM read, the divider start, the 23-step
// divider plus done and the output load. A flush output adds the same plus
// its drop read. The serial divider sets the pace. Invalid outputs skip
// the divider.
// Reset: window width goes to 51, sum, count, pointer and stream state clear.
// Entries of the delay line are only read after this stream wrote them.
// Stall: the output register holds a result until taken; a new sample is
// accepted meanwhile, and the sequencer waits before loading the next one.
module gap_aware_centered_moving_average_top
  import gacma_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_sample_value,
  input  logic               in_sample_valid,
  input  logic               in_stream_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [VALUE_W-1:0] out_smoothed_value,
  output logic               out_smoothed_valid,
  output logic               out_final_output,
  input  logic               cfg_wr_en,
  input  logic [CFG_W-1:0]   cfg_wr_data
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PLAN = 6'b000010,
    S_DROP = 6'b000100,
    S_OUT  = 6'b001000,
    S_DIV  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  typedef enum logic [5:0] {
    STEP_DROP0  = 6'b000001,
    STEP_OUT0   = 6'b000010,
    STEP_FLUSH0 = 6'b000100,
    STEP_FDROP  = 6'b001000,
    STEP_FOUT   = 6'b010000,
    STEP_DONE   = 6'b100000
  } step_t;

  state_t              state_r, state_nxt;
  step_t               step_r, step_nxt;
  logic [CFG_W-1:0]    cfg_width_r;
  logic [HALF_W-1:0]   half_r, half_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SEEN_W-1:0]   seen_r, seen_nxt;
  logic [PTR_W-1:0]    ptr_r, ptr_nxt;
  logic                end_r, end_nxt;
  logic [HALF_W-1:0]   d_r, d_nxt;
  logic                last_r, last_nxt;
  logic                neg_r, neg_nxt;
  logic                smv_r, smv_nxt;
  logic [VALUE_W-1:0]  res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic                out_svalid_r, out_svalid_nxt;
  logic                out_final_r, out_final_nxt;

  logic [HALF_W-1:0]   cfg_half;
  logic [CFG_W-1:0]    span;
  logic                accept;
  logic                rd_en;
  logic [PTR_W-1:0]    rd_addr;
  logic [VALUE_W:0]    rd_data;
  logic [SUM_W-1:0]    rd_sext;
  logic [SUM_W-1:0]    in_sext;
  logic [SUM_W-1:0]    mag;
  logic                div_start;
  logic [DVD_W-1:0]    div_dvd;
  logic [DVS_W-1:0]    div_dvs;
  logic                div_done;
  logic [DVD_W-1:0]    div_quo;
  logic [VALUE_W-1:0]  q;

  // odd-rounded width w gives half window w/2, which is cfg[5:1]
  assign cfg_half = (cfg_width_r[CFG_W-1:1] > MAX_HALF_WINDOW) ? MAX_HALF_WINDOW
                                                               : cfg_width_r[CFG_W-1:1];
  assign span     = {half_r, 1'b1};
  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign in_sext  = {{(SUM_W-VALUE_W){in_sample_value[VALUE_W-1]}}, in_sample_value};
  assign rd_sext  = {{(SUM_W-VALUE_W){rd_data[VALUE_W-1]}}, rd_data[VALUE_W-1:0]};
  assign mag      = sum_r[SUM_W-1] ? (~sum_r + SUM_W'(1)) : sum_r;
  assign q        = div_quo[VALUE_W-1:0];

  gacma_ram #(
    .WIDTH (VALUE_W + 1),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (ptr_r),
    .wr_data ({in_sample_valid, in_sample_value}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  gacma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    half_nxt       = half_r;
    sum_nxt        = sum_r;
    count_nxt      = count_r;
    seen_nxt       = seen_r;
    ptr_nxt        = ptr_r;
    end_nxt        = end_r;
    d_nxt          = d_r;
    last_nxt       = last_r;
    neg_nxt        = neg_r;
    smv_nxt        = smv_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_svalid_nxt = out_svalid_r;
    out_final_nxt  = out_final_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    div_start      = 1'b0;
    div_dvd        = '0;
    div_dvs        = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          // latch the half window at stream start
          half_nxt = (seen_r == '0) ? cfg_half : half_r;
          if (in_sample_valid) begin
            sum_nxt   = sum_r + in_sext;
            count_nxt = count_r + CNT_W'(1);
          end
          end_nxt   = in_stream_end;
          step_nxt  = STEP_DROP0;
          state_nxt = S_PLAN;
        end
      end
      S_PLAN: begin
        case (step_r)
          STEP_DROP0: begin
            step_nxt = STEP_OUT0;
            if (seen_r >= {1'b0, span}) begin
              rd_en     = 1'b1;
              rd_addr   = ptr_r - span;
              state_nxt = S_DROP;
            end
          end
          STEP_OUT0: begin
            step_nxt = STEP_FLUSH0;
            if (seen_r >= SEEN_W'(half_r)) begin
              rd_en     = 1'b1;
              rd_addr   = ptr_r - PTR_W'(half_r);
              last_nxt  = end_r && (half_r == '0);
              state_nxt = S_OUT;
            end
          end
          STEP_FLUSH0: begin
            if (end_r && (half_r != '0)) begin
              d_nxt    = (seen_r < SEEN_W'(half_r - HALF_W'(1))) ? seen_r[HALF_W-1:0]
                                                                  : half_r - HALF_W'(1);
              step_nxt = STEP_FDROP;
            end else begin
              step_nxt = STEP_DONE;
            end
          end
          STEP_FDROP: begin
            step_nxt = STEP_FOUT;
            if (seen_r >= SEEN_W'(d_r) + SEEN_W'(half_r) + SEEN_W'(1)) begin
              rd_en     = 1'b1;
              rd_addr   = ptr_r - PTR_W'(d_r) - PTR_W'(half_r) - PTR_W'(1);
              state_nxt = S_DROP;
            end
          end
          STEP_FOUT: begin
            rd_en     = 1'b1;
            rd_addr   = ptr_r - PTR_W'(d_r);
            last_nxt  = (d_r == '0);
            state_nxt = S_OUT;
            if (d_r == '0) begin
              step_nxt = STEP_DONE;
            end else begin
              d_nxt    = d_r - HALF_W'(1);
              step_nxt = STEP_FDROP;
            end
          end
          STEP_DONE: begin
            if (end_r) begin
              seen_nxt  = '0;
              ptr_nxt   = '0;
              sum_nxt   = '0;
              count_nxt = '0;
              half_nxt  = '0;
            end else begin
              ptr_nxt  = ptr_r + PTR_W'(1);
              seen_nxt = (seen_r == SEEN_CAP) ? SEEN_CAP : seen_r + SEEN_W'(1);
            end
            state_nxt = S_IDLE;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_DROP: begin
        // remove the leaving sample from the window
        if (rd_data[VALUE_W]) begin
          sum_nxt = sum_r - rd_sext;
          if (count_r != '0) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
        state_nxt = S_PLAN;
      end
      S_OUT: begin
        smv_nxt = rd_data[VALUE_W];
        neg_nxt = sum_r[SUM_W-1];
        if (rd_data[VALUE_W] && (count_r != '0)) begin
          // round half away from zero: (2|s| + c) / 2c
          div_start = 1'b1;
          div_dvd   = {mag[SUM_W-2:0], 1'b0} + DVD_W'(count_r);
          div_dvs   = {count_r[CNT_W-2:0], 1'b0};
          state_nxt = S_DIV;
        end else begin
          res_nxt   = '0;
          state_nxt = S_EMIT;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_nxt   = neg_r ? (~q + VALUE_W'(1)) : q;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_r;
          out_svalid_nxt = smv_r;
          out_final_nxt  = last_r;
          state_nxt      = S_PLAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP_DONE;
      cfg_width_r <= CFG_RESET;
      half_r      <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      seen_r      <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      if (cfg_wr_en) begin
        cfg_width_r <= cfg_wr_data;
      end
      half_r      <= half_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      seen_r      <= seen_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    end_r        <= end_nxt;
    d_r          <= d_nxt;
    last_r       <= last_nxt;
    neg_r        <= neg_nxt;
    smv_r        <= smv_nxt;
    res_r        <= res_nxt;
    out_value_r  <= out_value_nxt;
    out_svalid_r <= out_svalid_nxt;
    out_final_r  <= out_final_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_smoothed_value = out_value_r;
  assign out_smoothed_valid = out_svalid_r;
  assign out_final_output   = out_final_r;

`ifndef NO_ASSERTIONS
  a_count_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (count_r <= CNT_W'(span)))
    else $error("window count exceeds window span at output");

  a_gap_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_smoothed_valid) |-> (out_smoothed_value == '0))
    else $error("invalid output carries a nonzero value");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_PLAN))
    else $error("accepted transaction did not start the sequencer");
`endif

endmodule

>>> test/smoothing_checker.sv
// Checker for the gap-aware centered moving average: watches the sample, result and
// width ports, predicts the smoothed stream and compares it with what the block sends.
// Depends on gacma_pkg only.
module smoothing_checker
  import gacma_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [VALUE_W-1:0] in_sample_value,
  input  logic               in_sample_valid,
  input  logic               in_stream_end,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [VALUE_W-1:0] out_smoothed_value,
  input  logic               out_smoothed_valid,
  input  logic               out_final_output,
  input  logic               cfg_wr_en,
  input  logic [CFG_W-1:0]   cfg_wr_data,
  output int                 mismatch_count,
  output int                 results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               valid;
    logic               is_last;
  } smooth_result_t;

  smooth_result_t owed_results[$];

  logic [CFG_W-1:0]          width_reg;
  logic signed [VALUE_W-1:0] line_val [LINE_DEPTH];
  bit                        line_ok  [LINE_DEPTH];
  int signed                 win_sum;
  int unsigned               win_count;
  int unsigned               seen;
  logic [PTR_W-1:0]          wr_ptr;
  int unsigned               half_now;
  int                        results_seen;

  function automatic void clear_window();
    for (int i = 0; i < LINE_DEPTH; i++) begin
      line_val[i] = '0;
      line_ok[i]  = 1'b0;
    end
    win_sum   = 0;
    win_count = 0;
    seen      = 0;
    wr_ptr    = '0;
    half_now  = 0;
  endfunction

  function automatic int unsigned half_of(logic [CFG_W-1:0] w);
    int unsigned h;
    // width 0 counts as 1, even widths round up to odd
    h = (int'(w) | 1) >> 1;
    if (h > MAX_HALF_WINDOW) h = MAX_HALF_WINDOW;
    return h;
  endfunction

  // Round half away from zero.
  function automatic logic [VALUE_W-1:0] round_avg(int signed s, int unsigned c);
    int unsigned mag;
    int unsigned q;
    int signed   r;
    if (c == 0) return '0;
    mag = (s < 0) ? -s : s;
    q   = (2 * mag + c) / (2 * c);
    r   = int'(q);
    if (s < 0) r = -r;
    return r[VALUE_W-1:0];
  endfunction

  function automatic void drop_slot(logic [PTR_W-1:0] idx);
    if (line_ok[idx]) begin
      win_sum = win_sum - line_val[idx];
      if (win_count > 0) win_count--;
    end
  endfunction

  function automatic void owe_result(logic [PTR_W-1:0] idx, logic is_last);
    smooth_result_t r;
    r.value   = line_ok[idx] ? round_avg(win_sum, win_count) : '0;
    r.valid   = line_ok[idx];
    r.is_last = is_last;
    owed_results.push_back(r);
  endfunction

  function automatic void smooth_sample(logic [VALUE_W-1:0] raw, logic ok, logic end_mark);
    int unsigned      h;
    int unsigned      j;
    logic [PTR_W-1:0] p;
    int               d;
    // latch the half window on the first sample of a stream
    if (seen == 0) half_now = half_of(width_reg);
    h = half_now;
    j = seen;
    p = wr_ptr;
    if (j >= 2 * h + 1) drop_slot(PTR_W'(p - (2 * h + 1)));
    line_val[p] = raw;
    line_ok[p]  = ok;
    if (ok) begin
      win_sum = win_sum + line_val[p];
      win_count++;
    end
    if (j >= h) owe_result(PTR_W'(p - h), end_mark && h == 0);
    if (end_mark) begin
      // flush the tail, shrinking the window from the left
      if (h > 0) begin
        d = (j < h - 1) ? j : h - 1;
        for (; d >= 0; d--) begin
          if (j >= d + h + 1) drop_slot(PTR_W'(p - d - h - 1));
          owe_result(PTR_W'(p - d), d == 0);
        end
      end
      clear_window();
    end else begin
      wr_ptr = p + 1'b1;
      seen   = (j + 1 > SEEN_CAP) ? SEEN_CAP : j + 1;
    end
  endfunction

  always @(posedge clk) begin : watch
    smooth_result_t want;
    if (!rst_n) begin
      width_reg      = CFG_RESET;
      mismatch_count = 0;
      results_seen   = 0;
      owed_results.delete();
      clear_window();
    end else begin
      // compare before predicting: a result never leaves with its own transaction
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result %0d with none owed: value %0d valid %b last %b", $time,
                     results_seen, $signed(out_smoothed_value), out_smoothed_valid,
                     out_final_output);
        end else begin
          want = owed_results.pop_front();
          if (want.value !== out_smoothed_value || want.valid !== out_smoothed_valid ||
              want.is_last !== out_final_output) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t: result %0d: value %0d/%0d valid %b/%b last %b/%b (exp/got)",
                       $time, results_seen, $signed(want.value), $signed(out_smoothed_value),
                       want.valid, out_smoothed_valid, want.is_last, out_final_output);
          end
        end
        results_seen++;
      end
      if (in_valid && in_ready) smooth_sample(in_sample_value, in_sample_valid, in_stream_end);
      if (cfg_wr_en) width_reg = cfg_wr_data;
    end
    results_owed <= owed_results.size();
  end

endmodule

>>> test/tb.sv
// Top of the moving average testbench: clock, reset, sample and width stimulus, output
// stalls and the verdict. Depends on gacma_pkg, the block and smoothing_checker.
module tb
  import gacma_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 10;
  localparam int IDLE_PCT      = 23;
  localparam int SETTLE_CYCLES = 48;
  localparam int RANDOM_ITEMS  = 155;

  typedef enum {FULL_RANGE, NEAR_ZERO, RAILS} value_mix_t;

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               in_valid        = 1'b0;
  logic [VALUE_W-1:0] in_sample_value = '0;
  logic               in_sample_valid = 1'b0;
  logic               in_stream_end   = 1'b0;
  logic               out_ready       = 1'b0;
  logic               cfg_wr_en       = 1'b0;
  logic [CFG_W-1:0]   cfg_wr_data     = '0;
  logic               in_ready;
  logic               out_valid;
  logic [VALUE_W-1:0] out_smoothed_value;
  logic               out_smoothed_valid;
  logic               out_final_output;
  int                 mismatch_count;
  int                 results_owed;

  int unsigned        gap_pct  = IDLE_PCT;
  bit                 no_stall = 1'b0;
  logic [CFG_W-1:0]   width_now = CFG_RESET;

  gap_aware_centered_moving_average_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample_value    (in_sample_value),
    .in_sample_valid    (in_sample_valid),
    .in_stream_end      (in_stream_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_smoothed_value (out_smoothed_value),
    .out_smoothed_valid (out_smoothed_valid),
    .out_final_output   (out_final_output),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  smoothing_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample_value    (in_sample_value),
    .in_sample_valid    (in_sample_valid),
    .in_stream_end      (in_stream_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_smoothed_value (out_smoothed_value),
    .out_smoothed_valid (out_smoothed_valid),
    .out_final_output   (out_final_output),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .mismatch_count     (mismatch_count),
    .results_owed       (results_owed)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) out_ready <= no_stall || ($urandom_range(0, 99) >= IDLE_PCT);

  initial begin
    #20ms;
    $display("tb NOT OK");
    $finish;
  end

  task automatic send_sample(input logic [VALUE_W-1:0] value, input logic ok,
                             input logic end_mark);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_value <= value;
    in_sample_valid <= ok;
    in_stream_end   <= end_mark;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drain every owed result, then give the sequencer time to go idle.
  task automatic wait_settled();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_width(input logic [CFG_W-1:0] w);
    wait_settled();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    width_now   = w;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic send_stream(input int len, input value_mix_t mix, input int unsigned valid_pct);
    logic [VALUE_W-1:0] v;
    for (int k = 0; k < len; k++) begin
      case (mix)
        NEAR_ZERO: v = VALUE_W'($urandom_range(0, 6) - 3);
        RAILS: begin
          if ($urandom_range(0, 1)) v = 16'h7FFF - VALUE_W'($urandom_range(0, 3));
          else v = 16'h8000 + VALUE_W'($urandom_range(0, 3));
        end
        default: v = VALUE_W'($urandom);
      endcase
      send_sample(v, $urandom_range(0, 99) < valid_pct, k == len - 1);
    end
  endtask

  initial begin : stimulus
    int          sent;
    int          len;
    int unsigned h;
    int unsigned valid_pct;
    bit          long_done;
    value_mix_t  mix;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset width 51: a stream shorter than the half window, flushed at its end
    send_sample(16'h7FFF, 1'b1, 1'b0);
    send_sample(16'h8000, 1'b1, 1'b0);
    send_sample(16'h0000, 1'b0, 1'b1);

    // width 0 acts as 1: every sample is its own window
    set_width(6'd0);
    send_sample(16'h8000, 1'b1, 1'b0);
    send_sample(16'h7FFF, 1'b1, 1'b0);
    send_sample(16'h0005, 1'b0, 1'b1);
    send_sample(16'h0007, 1'b1, 1'b1);

    // even width rounds up to 3
    set_width(6'd2);
    send_sample(VALUE_W'(100), 1'b1, 1'b0);
    send_sample(VALUE_W'(-3), 1'b0, 1'b0);
    send_sample(VALUE_W'(-101), 1'b1, 1'b0);
    send_sample(VALUE_W'(50), 1'b1, 1'b1);
    send_sample(VALUE_W'(9), 1'b1, 1'b1);

    // width change mid-stream holds until the next stream
    send_sample(VALUE_W'(20), 1'b1, 1'b0);
    set_width(6'd63);
    send_sample(VALUE_W'(21), 1'b1, 1'b0);
    send_sample(VALUE_W'(-22), 1'b1, 1'b0);
    send_sample(VALUE_W'(0), 1'b0, 1'b1);

    // widest window, short stream at the positive rail
    send_sample(16'h7FFF, 1'b1, 1'b0);
    send_sample(16'h7FFF, 1'b1, 1'b0);
    send_sample(16'h7FFF, 1'b1, 1'b0);
    send_sample(16'h7FFF, 1'b0, 1'b1);

    set_width(6'd1);
    send_sample(VALUE_W'(1), 1'b1, 1'b1);

    sent      = 0;
    long_done = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (!long_done && sent >= 40) begin
        // long stream with a small window: the seen counter saturates
        set_width(CFG_W'($urandom_range(0, 8)));
        long_done = 1'b1;
        len = $urandom_range(70, 80);
      end else begin
        if ($urandom_range(0, 1)) begin
          case ($urandom_range(0, 5))
            0:       set_width(6'd0);
            1:       set_width(6'd63);
            2:       set_width(CFG_W'($urandom));
            default: set_width(CFG_W'($urandom_range(1, 10)));
          endcase
        end
        h = (int'(width_now) | 1) >> 1;
        if ($urandom_range(0, 9) < 7) len = $urandom_range(1, 12);
        else len = $urandom_range(h + 1, 2 * h + 6);
      end
      case ($urandom_range(0, 7))
        0:       valid_pct = 0;
        1:       valid_pct = 100;
        default: valid_pct = 75;
      endcase
      mix      = value_mix_t'($urandom_range(0, 2));
      no_stall = (sent >= 70 && sent < 120);
      gap_pct  = no_stall ? 0 : IDLE_PCT;
      send_stream(len, mix, valid_pct);
      sent += len;
    end

    no_stall = 1'b0;
    gap_pct  = IDLE_PCT;
    wait_settled();
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
